// File: sv/b64enc_pkg.sv
package b64enc_pkg;

    localparam logic [7:0] GPL_RESET    = 8'd19;
    localparam logic [7:0] NEWLINE_CHAR = 8'd10;
    localparam logic [7:0] PAD_CHAR     = 8'd61;

    localparam logic       OP_DATA  = 1'b0;
    localparam logic       OP_FLUSH = 1'b1;

    localparam logic       REG_GROUPS_PER_LINE = 1'b0;

    // one encoded group waiting for the output side
    typedef struct packed {
        logic [3:0][7:0] chars;
        logic            newline;
    } t_job;

    function automatic logic [7:0] sym(input logic [5:0] six);
        logic [7:0] w;
        w = {2'b00, six};
        if (six < 6'd26) begin
            return w + 8'd65;
        end else if (six < 6'd52) begin
            return w + 8'd71;
        end else if (six < 6'd62) begin
            return w - 8'd4;
        end else if (six == 6'd62) begin
            return 8'd43;
        end else begin
            return 8'd47;
        end
    endfunction

endpackage

// File: sv/b64enc_ifs.sv
interface b64enc_in_if;
    logic       valid;
    logic       ready;
    logic       operation;
    logic [7:0] data_byte;

    modport source (output valid, output operation, output data_byte, input ready);
    modport sink   (input valid, input operation, input data_byte, output ready);
endinterface

interface b64enc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] character;
    logic       last;

    modport source (output valid, output character, output last, input ready);
    modport sink   (input valid, input character, input last, output ready);
endinterface

// File: sv/b64enc_front.sv
module b64enc_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    b64enc_in_if.sink           i_in,
    input  logic [7:0]          i_groups_per_line,
    output logic                o_job_valid,
    output b64enc_pkg::t_job    o_job,
    input  logic                i_job_ready
);

    logic [15:0] r_held, n_held;
    logic [1:0]  r_cnt, n_cnt;
    logic [7:0]  r_gc, n_gc;
    logic        accept;
    logic [7:0]  gc_inc;
    logic        line_hit;
    logic [7:0]  b0, b1, b2, s0;

    assign i_in.ready = i_job_ready;
    assign accept     = i_in.valid && i_job_ready;
    assign gc_inc     = r_gc + 8'd1;
    assign line_hit   = (gc_inc == i_groups_per_line);
    assign b0         = r_held[15:8];
    assign b1         = r_held[7:0];
    assign b2         = i_in.data_byte;
    assign s0         = r_held[7:0];

    always_comb begin
        n_held      = r_held;
        n_cnt       = r_cnt;
        n_gc        = r_gc;
        o_job_valid = 1'b0;
        o_job       = '0;
        if (accept) begin
            if (i_in.operation == b64enc_pkg::OP_DATA) begin
                if (r_cnt < 2'd2) begin
                    n_held = {r_held[7:0], i_in.data_byte};
                    n_cnt  = r_cnt + 2'd1;
                end else begin
                    o_job_valid     = 1'b1;
                    o_job.chars[0]  = b64enc_pkg::sym(b0[7:2]);
                    o_job.chars[1]  = b64enc_pkg::sym({b0[1:0], b1[7:4]});
                    o_job.chars[2]  = b64enc_pkg::sym({b1[3:0], b2[7:6]});
                    o_job.chars[3]  = b64enc_pkg::sym(b2[5:0]);
                    o_job.newline   = line_hit;
                    n_held          = '0;
                    n_cnt           = '0;
                    n_gc            = line_hit ? 8'd0 : gc_inc;
                end
            end else if (r_cnt != 2'd0) begin
                o_job_valid = 1'b1;
                if (r_cnt == 2'd1) begin
                    o_job.chars[0] = b64enc_pkg::sym(s0[7:2]);
                    o_job.chars[1] = b64enc_pkg::sym({s0[1:0], 4'b0000});
                    o_job.chars[2] = b64enc_pkg::PAD_CHAR;
                end else begin
                    o_job.chars[0] = b64enc_pkg::sym(b0[7:2]);
                    o_job.chars[1] = b64enc_pkg::sym({b0[1:0], b1[7:4]});
                    o_job.chars[2] = b64enc_pkg::sym({b1[3:0], 2'b00});
                end
                o_job.chars[3] = b64enc_pkg::PAD_CHAR;
                o_job.newline  = 1'b0;
                n_held         = '0;
                n_cnt          = '0;
                n_gc           = line_hit ? 8'd0 : gc_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= '0;
            r_cnt  <= '0;
            r_gc   <= '0;
        end else begin
            r_held <= n_held;
            r_cnt  <= n_cnt;
            r_gc   <= n_gc;
        end
    end

endmodule

// File: sv/b64enc_queue.sv
module b64enc_queue #(
    parameter int DEPTH = 2
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  b64enc_pkg::t_job    i_job,
    output logic                o_not_full,
    input  logic                i_pop,
    output logic                o_valid,
    output b64enc_pkg::t_job    o_job
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    b64enc_pkg::t_job   r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr, r_rd;
    logic [CNT_W-1:0]   r_count;
    logic               push, pop;

    assign o_not_full = (r_count < CNT_W'(DEPTH));
    assign o_valid    = (r_count != '0);
    assign o_job      = r_mem[r_rd];
    assign push       = i_push && o_not_full;
    assign pop        = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("queue count over depth");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !pop) |=> r_count == $past(r_count) + 1'b1)
        else $error("push lost");

    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> o_not_full)
        else $error("job pushed into full queue");

endmodule

// File: sv/b64enc_back.sv
module b64enc_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_job_valid,
    input  b64enc_pkg::t_job    i_job,
    output logic                o_pop,
    b64enc_out_if.source        o_out
);

    logic       r_valid, n_valid;
    logic [7:0] r_char, n_char;
    logic       r_last, n_last;
    logic [2:0] r_idx, n_idx;
    logic       load;
    logic       is_last;

    assign load        = !r_valid || o_out.ready;
    assign o_out.valid = r_valid;
    assign o_out.character = r_char;
    assign o_out.last  = r_last;

    always_comb begin
        n_valid = r_valid;
        n_char  = r_char;
        n_last  = r_last;
        n_idx   = r_idx;
        o_pop   = 1'b0;
        is_last = (r_idx == 3'd4) || (r_idx == 3'd3 && !i_job.newline);
        if (load) begin
            n_valid = i_job_valid;
            if (i_job_valid) begin
                n_char = (r_idx == 3'd4) ? b64enc_pkg::NEWLINE_CHAR
                                         : i_job.chars[r_idx[1:0]];
                n_last = is_last;
                n_idx  = is_last ? 3'd0 : r_idx + 3'd1;
                o_pop  = is_last;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            r_valid <= n_valid;
            r_idx   <= n_idx;
        end
        r_char <= n_char;
        r_last <= n_last;
    end

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= 3'd4)
        else $error("character index out of range");

    a_newline_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_char == b64enc_pkg::NEWLINE_CHAR) |-> r_last)
        else $error("newline not marked last");

    a_pop_resets_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> r_idx == 3'd0)
        else $error("index not cleared after group");

endmodule

// File: sv/base64_stream_encoder_line_wrap.sv
// channel   dir  handshake      payload
// i_in      in   valid/ready    operation, data_byte
// o_out     out  valid/ready    character, last
// apb       in   psel/penable   paddr, pwdata -> groups_per_line
//
// One item accepted per cycle while the job queue has room. A group leaves
// as 4 characters, or 5 with a newline, one per cycle while o_out is ready.
// The output register drains one character per cycle; its stall backs up the
// queue and only then the input. Synchronous active-low reset clears held
// bytes, group count and queue; groups_per_line returns to 19.
module base64_stream_encoder_line_wrap #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    b64enc_in_if.sink    i_in,
    b64enc_out_if.source o_out,
    input  logic         i_psel,
    input  logic         i_penable,
    input  logic         i_pwrite,
    input  logic [2:0]   i_paddr,
    input  logic [31:0]  i_pwdata,
    output logic [31:0]  o_prdata,
    output logic         o_pready
);

    logic [7:0]       r_groups_per_line;
    logic             cfg_wr;
    logic             sel_gpl;
    logic             f_job_valid;
    b64enc_pkg::t_job f_job;
    logic             q_not_full;
    logic             q_valid;
    b64enc_pkg::t_job q_job;
    logic             b_pop;

    assign o_pready = 1'b1;
    assign sel_gpl  = (i_paddr[2] == b64enc_pkg::REG_GROUPS_PER_LINE);
    assign cfg_wr   = i_psel && i_penable && i_pwrite && sel_gpl;
    assign o_prdata = sel_gpl ? {24'd0, r_groups_per_line} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_groups_per_line <= b64enc_pkg::GPL_RESET;
        end else if (cfg_wr) begin
            r_groups_per_line <= i_pwdata[7:0];
        end
    end

    b64enc_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in              (i_in),
        .i_groups_per_line (r_groups_per_line),
        .o_job_valid       (f_job_valid),
        .o_job             (f_job),
        .i_job_ready       (q_not_full)
    );

    b64enc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (f_job_valid),
        .i_job      (f_job),
        .o_not_full (q_not_full),
        .i_pop      (b_pop),
        .o_valid    (q_valid),
        .o_job      (q_job)
    );

    b64enc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (q_valid),
        .i_job       (q_job),
        .o_pop       (b_pop),
        .o_out       (o_out)
    );

endmodule

// File: test/base64_stream_encoder_line_wrap_tb.sv
`timescale 1ns / 100ps

module base64_stream_encoder_line_wrap_tb;

    localparam int QUIET_LIMIT   = 3000;
    localparam int ITEMS_PER_RUN = 32;
    localparam int N_DIRECTED    = 21;
    localparam int N_PHASES      = 7;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_char_exp;

    typedef struct {
        logic       op;
        logic [7:0] data;
        string      want;
    } t_dir_row;

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    b64enc_in_if  in_ch();
    b64enc_out_if out_ch();

    base64_stream_encoder_line_wrap u_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (in_ch),
        .o_out     (out_ch),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_prdata  (prdata),
        .o_pready  (pready)
    );

    // encoder mirror
    string       b64_tab = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
    logic [7:0]  line_len = b64enc_pkg::GPL_RESET;
    logic [15:0] held_q   = '0;
    logic [1:0]  held_cnt = '0;
    logic [7:0]  grp_cnt  = '0;

    t_char_exp   new_chars[$];
    t_char_exp   char_q[$];
    int          errs = 0;
    int          quiet_cycles = 0;
    bit          idle_on = 1'b1;
    bit          long_hold = 1'b0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    task automatic report_miss(input string what);
        errs++;
        $display("%0t mismatch: %s", $time, what);
    endtask

    function automatic void add_char(input logic [7:0] c);
        new_chars.insert(new_chars.size(), t_char_exp'{c, 1'b0});
    endfunction

    function automatic void put_sym(input logic [5:0] six);
        add_char(b64_tab[six]);
    endfunction

    function automatic bit bump_group();
        logic [7:0] nxt;
        nxt = grp_cnt + 8'd1;
        if (nxt == line_len) begin
            grp_cnt = '0;
            return 1'b1;
        end
        grp_cnt = nxt;
        return 1'b0;
    endfunction

    function automatic void encode_item(input logic op, input logic [7:0] b);
        logic [7:0] b0;
        logic [7:0] b1;
        new_chars.delete();
        if (op == b64enc_pkg::OP_DATA) begin
            if (held_cnt < 2'd2) begin
                held_q   = {held_q[7:0], b};
                held_cnt = held_cnt + 2'd1;
                return;
            end
            b0 = held_q[15:8];
            b1 = held_q[7:0];
            put_sym(b0[7:2]);
            put_sym({b0[1:0], b1[7:4]});
            put_sym({b1[3:0], b[7:6]});
            put_sym(b[5:0]);
            held_q   = '0;
            held_cnt = '0;
            if (bump_group()) add_char(b64enc_pkg::NEWLINE_CHAR);
        end else begin
            if (held_cnt == 2'd0) return;
            if (held_cnt == 2'd1) begin
                b0 = held_q[7:0];
                put_sym(b0[7:2]);
                put_sym({b0[1:0], 4'b0000});
                add_char(b64enc_pkg::PAD_CHAR);
                add_char(b64enc_pkg::PAD_CHAR);
            end else begin
                b0 = held_q[15:8];
                b1 = held_q[7:0];
                put_sym(b0[7:2]);
                put_sym({b0[1:0], b1[7:4]});
                put_sym({b1[3:0], 2'b00});
                add_char(b64enc_pkg::PAD_CHAR);
            end
            held_q   = '0;
            held_cnt = '0;
            void'(bump_group());
        end
        new_chars[new_chars.size() - 1].last = 1'b1;
    endfunction

    task automatic push_item(input logic op, input logic [7:0] b, input string want);
        int k;
        bit took;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.operation <= op;
        in_ch.data_byte <= b;
        // ready only moves on rising edges; sample it mid-cycle
        do begin
            @(negedge i_clk);
            took = in_ch.ready;
            @(posedge i_clk);
        end while (!took);
        encode_item(op, b);
        if (want.len() != 0) begin
            new_chars.delete();
            for (k = 0; k < want.len(); k++) begin
                new_chars.insert(new_chars.size(),
                                 t_char_exp'{want[k], k == want.len() - 1});
            end
        end
        foreach (new_chars[j]) char_q.insert(char_q.size(), new_chars[j]);
    endtask

    // drain, then give the block time to finish items that produce nothing
    task automatic settle();
        in_ch.valid <= 1'b0;
        while (char_q.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    // write, then read back in the following transfer
    task automatic write_gpl(input logic [7:0] v);
        logic [23:0] junk;
        junk    = 24'($urandom_range(0, 32'h00FF_FFFF));
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {b64enc_pkg::REG_GROUPS_PER_LINE, 2'b00};
        pwdata  <= {junk, v};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        line_len = v;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata[7:0] !== v) begin
            report_miss($sformatf("groups_per_line read %h, wrote %h", prdata[7:0], v));
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // output side
    initial begin
        int         hold_left;
        t_char_exp  want_c;
        bit         fire;
        logic [7:0] seen_ch;
        logic       seen_last;
        hold_left    = 0;
        out_ch.ready = 1'b0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            @(negedge i_clk);
            fire      = out_ch.valid && out_ch.ready;
            seen_ch   = out_ch.character;
            seen_last = out_ch.last;
            @(posedge i_clk);
            if (fire) begin
                if (char_q.size() == 0) begin
                    report_miss($sformatf("unexpected char %h", seen_ch));
                end else begin
                    want_c = char_q.pop_front();
                    if (seen_ch !== want_c.ch) begin
                        report_miss($sformatf("char %h, want %h", seen_ch, want_c.ch));
                    end
                    if (seen_last !== want_c.last) begin
                        report_miss($sformatf("last %b, want %b on char %h",
                                              seen_last, want_c.last, want_c.ch));
                    end
                end
            end
            if (long_hold) begin
                hold_left = 90;
                long_hold = 1'b0;
            end else if (hold_left == 0 && idle_on && $urandom_range(0, 5) == 0) begin
                hold_left = $urandom_range(1, 11);
            end
            if (hold_left > 0) begin
                out_ch.ready <= 1'b0;
                hold_left--;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || psel) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles == QUIET_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        t_dir_row   dir_rows[N_DIRECTED];
        logic [7:0] gpl_plan[N_PHASES];
        logic       rnd_op;
        logic [7:0] rnd_byte;
        int         done;
        int         p;
        int         r;

        in_ch.valid     = 1'b0;
        in_ch.operation = b64enc_pkg::OP_DATA;
        in_ch.data_byte = '0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;

        dir_rows = '{
            '{b64enc_pkg::OP_FLUSH, 8'hA5, ""},
            '{b64enc_pkg::OP_DATA,  8'h00, ""},
            '{b64enc_pkg::OP_DATA,  8'h00, ""},
            '{b64enc_pkg::OP_DATA,  8'h00, "AAAA"},
            '{b64enc_pkg::OP_DATA,  8'hFF, ""},
            '{b64enc_pkg::OP_DATA,  8'hFF, ""},
            '{b64enc_pkg::OP_DATA,  8'hFF, "////"},
            '{b64enc_pkg::OP_DATA,  8'h4D, ""},
            '{b64enc_pkg::OP_FLUSH, 8'h00, "TQ=="},
            '{b64enc_pkg::OP_DATA,  8'h4D, ""},
            '{b64enc_pkg::OP_DATA,  8'h61, ""},
            '{b64enc_pkg::OP_FLUSH, 8'hFF, "TWE="},
            '{b64enc_pkg::OP_DATA,  8'hFF, ""},
            '{b64enc_pkg::OP_FLUSH, 8'h5A, "/w=="},
            '{b64enc_pkg::OP_DATA,  8'hFF, ""},
            '{b64enc_pkg::OP_DATA,  8'hFF, ""},
            '{b64enc_pkg::OP_FLUSH, 8'h00, "//8="},
            '{b64enc_pkg::OP_DATA,  8'h4D, ""},
            '{b64enc_pkg::OP_DATA,  8'h61, ""},
            '{b64enc_pkg::OP_DATA,  8'h6E, "TWFu"},
            '{b64enc_pkg::OP_FLUSH, 8'h00, ""}
        };
        gpl_plan = '{8'd1, 8'd2, 8'd255, 8'd0, 8'd3, 8'd1, 8'd2};
        gpl_plan[4] = 8'($urandom_range(3, 9));

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (r = 0; r < N_DIRECTED; r++) begin
            push_item(dir_rows[r].op, dir_rows[r].data, dir_rows[r].want);
        end

        for (p = 0; p < N_PHASES; p++) begin
            settle();
            write_gpl(gpl_plan[p]);
            idle_on = (p < 5);
            // one phase with a long output stall and a steady sender
            if (p == 5) long_hold = 1'b1;
            done = 0;
            while (done < ITEMS_PER_RUN) begin
                rnd_op   = ($urandom_range(0, 4) == 0) ? b64enc_pkg::OP_FLUSH
                                                       : b64enc_pkg::OP_DATA;
                rnd_byte = 8'($urandom_range(0, 255));
                if (!(rnd_op == b64enc_pkg::OP_FLUSH && held_cnt == 2'd0)) done++;
                push_item(rnd_op, rnd_byte, "");
            end
        end

        settle();
        repeat (20) @(posedge i_clk);
        if (errs == 0 && char_q.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// File: sim.f
sv/b64enc_pkg.sv
sv/b64enc_ifs.sv
sv/b64enc_front.sv
sv/b64enc_queue.sv
sv/b64enc_back.sv
sv/base64_stream_encoder_line_wrap.sv
test/base64_stream_encoder_line_wrap_tb.sv
